[rtl/exchange_sort_engine_top_macros.svh]
// Assertion helpers used by the checker file.
`ifndef EXCHANGE_SORT_ENGINE_TOP_MACROS_SVH
`define EXCHANGE_SORT_ENGINE_TOP_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define ESE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ESE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/esort_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esort_pkg;

  // Width of one element
  localparam int unsigned DATA_W = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_OUTER,
    ST_LOADA,
    ST_INNER,
    ST_WRI,
    ST_EMIT,
    ST_EWAIT
  } state_e;

endpackage

`default_nettype wire

[rtl/exchange_sort_engine_top.sv]
// Load: one element per cycle while s_axis_tready is high; the transfer with tlast closes the set.
// Sort: for n held elements, outer pass i holds element i, streams the later positions through the
//   store's single read and write port pair, swapping larger ones, then writes the minimum back to i.
// Emit: n results, each read from the store and then registered, the final one with tlast.
// Input is not taken from the closing transfer until the last result is in the output register.
// Reset clears control state only; store contents are undefined and are never read unwritten.
`timescale 1ns / 1ps
`default_nettype none

module exchange_sort_engine_top #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [esort_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] value
  input  wire logic                          s_axis_tlast,   // last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [esort_pkg::DATA_W-1:0]       m_axis_tdata,   // [31:0] sorted_value
  output logic                               m_axis_tlast,   // last_out
  output logic                               m_axis_tuser    // [0] dropped
);
  import esort_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0]     fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [AW-1:0]     i_q, i_d;
  logic [CW-1:0]     j_q, j_d;
  logic [AW-1:0]     cj_q, cj_d;
  logic              pend_q, pend_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [CW-1:0]     k_q, k_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;
  logic              out_drop_q, out_drop_d;

  // Store ports
  logic [DATA_W-1:0] store_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic          s_acc;
  logic          has_room;
  logic [CW-1:0] fill_next;
  logic          inner_more;

  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign has_room   = fill_q < CW'(DEPTH);
  assign fill_next  = has_room ? fill_q + CW'(1) : fill_q;
  assign inner_more = j_q < fill_q;

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[mem_raddr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (s_acc && s_axis_tlast) begin
          state_d = (fill_next >= CW'(2)) ? ST_OUTER : ST_EMIT;
        end
      end
      ST_OUTER: state_d = ST_LOADA;
      ST_LOADA: state_d = ST_INNER;
      ST_INNER: begin
        if (!inner_more) begin
          state_d = ST_WRI;
        end
      end
      ST_WRI: begin
        state_d = ((CW'(i_q) + CW'(2)) < fill_q) ? ST_OUTER : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_EWAIT;
        end
      end
      ST_EWAIT: begin
        state_d = ((k_q + CW'(1)) == fill_q) ? ST_LOAD : ST_EMIT;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    fill_d     = fill_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    cj_d       = cj_q;
    pend_d     = pend_q;
    a_d        = a_q;
    k_d        = k_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    out_drop_d = out_drop_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = i_q;
    mem_raddr  = i_q;
    mem_wdata  = a_q;
    case (state_q)
      ST_LOAD: begin
        if (s_acc) begin
          if (has_room) begin
            mem_we    = 1'b1;
            mem_waddr = fill_q[AW-1:0];
            mem_wdata = s_axis_tdata;
          end else begin
            ovf_d = 1'b1;
          end
          fill_d = fill_next;
          if (s_axis_tlast) begin
            i_d = '0;
            k_d = '0;
          end
        end
      end
      ST_OUTER: begin
        // fetch the element at the outer position
        mem_re    = 1'b1;
        mem_raddr = i_q;
        j_d       = CW'(i_q) + CW'(1);
      end
      ST_LOADA: begin
        // hold the outer element, start streaming later positions
        a_d       = rd_data_q;
        mem_re    = 1'b1;
        mem_raddr = j_q[AW-1:0];
        cj_d      = j_q[AW-1:0];
        pend_d    = 1'b1;
        j_d       = j_q + CW'(1);
      end
      ST_INNER: begin
        pend_d = 1'b0;
        if (inner_more) begin
          mem_re    = 1'b1;
          mem_raddr = j_q[AW-1:0];
          cj_d      = j_q[AW-1:0];
          pend_d    = 1'b1;
          j_d       = j_q + CW'(1);
        end
        // compare and swap with the returned element
        if (pend_q && ($signed(a_q) > $signed(rd_data_q))) begin
          mem_we    = 1'b1;
          mem_waddr = cj_q;
          mem_wdata = a_q;
          a_d       = rd_data_q;
        end
      end
      ST_WRI: begin
        // write back the minimum to the outer position and advance
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = a_q;
        i_d       = i_q + AW'(1);
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          mem_re    = 1'b1;
          mem_raddr = k_q[AW-1:0];
        end
      end
      ST_EWAIT: begin
        out_vld_d  = 1'b1;
        out_data_d = rd_data_q;
        out_last_d = (k_q + CW'(1)) == fill_q;
        out_drop_d = ovf_q;
        k_d        = k_q + CW'(1);
        if ((k_q + CW'(1)) == fill_q) begin
          fill_d = '0;
          ovf_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      cj_q      <= '0;
      pend_q    <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      cj_q      <= cj_d;
      pend_q    <= pend_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

endmodule

`default_nettype wire

[rtl/esort_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "exchange_sort_engine_top_macros.svh"

module esort_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // A closing transfer drops input ready right after it
  `ESE_ASSERT_NEXT(a_close_blocks, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken right after closing transfer")

  // No input while a set is still being emitted
  `ESE_ASSERT(a_emit_blocks, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready, "input ready in mid-set output")

  // Stalled result holds its payload
  `ESE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind exchange_sort_engine_top esort_checker u_esort_checker (.*);

`default_nettype wire
